[design/lfra_pkg.sv]
// Package for the lowest free room allocator.
// Holds the sizing constants, widths and the stream command codes.
// No dependencies.
package lfra_pkg;

    localparam int MAX_ROOMS     = 64;
    localparam int MAX_CUSTOMERS = 1024;

    // Fixed widths of the stream fields.
    localparam int CUST_W     = 10;
    localparam int ROOM_OUT_W = 7;

    // Internal widths derived from the sizes.
    localparam int ROOM_W = $clog2(MAX_ROOMS + 1);
    localparam int IDX_W  = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int ADDR_W = (MAX_CUSTOMERS > 1) ? $clog2(MAX_CUSTOMERS) : 1;

    localparam int IN_DATA_W  = ((CUST_W + 7) / 8) * 8;
    localparam int OUT_BITS   = 2 * ROOM_OUT_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [ROOM_W-1:0]    room_t;
    typedef logic [MAX_ROOMS-1:0] room_map_t;
    typedef logic [ADDR_W-1:0]    cust_addr_t;

    typedef enum logic
    {
        CMD_ARRIVAL   = 1'b0,
        CMD_DEPARTURE = 1'b1
    } cmd_t;

endpackage

[design/lfra_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module lfra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/lowest_free_room_allocator.sv]
// Top level of the lowest free room allocator.
// Depends on lfra_pkg and the lfra_ram table memory.
//
// Channel   Direction  Signals                    Content
// s_*       in         s_tvalid s_tready s_tdata  request: tuser = command, tdata = customer
//                      s_tuser
// m_*       out        m_tvalid m_tready m_tdata  result: room, rooms_opened, full_res
//
// Each request passes through the customer table read and then the free map
// update into the result register. A new request is accepted every cycle
// while m_tready does not stall the result register; the rate is set by the
// free map register and its priority encoder. Reset clears the free map,
// the open room count and all valid flags; the customer table is not
// cleared. When m_tready is low the result register holds, and one more
// request may sit in the table read stage before s_tready drops.
module lowest_free_room_allocator
    import lfra_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [9:0] customer, rest zero
    input  logic                  s_tuser,   // [0] command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [6:0] room, [13:7] rooms_opened,
                                             // [14] full_res, rest zero
);

    // Stage one: request waiting for its table read.
    logic       s1_valid_reg;
    cmd_t       s1_cmd_reg;
    cust_addr_t s1_addr_reg;
    logic       s1_in_range_reg;

    // Last table write, forwarded over the read that happened at the same edge.
    logic       fwd_valid_reg;
    cust_addr_t fwd_addr_reg;
    room_t      fwd_data_reg;

    room_map_t  free_map_reg, free_map_next;
    room_t      opened_reg, opened_next;

    logic       out_valid_reg;
    room_t      out_room_reg, out_room_next;
    logic       out_full_reg, out_full_next;

    logic       s_accept;
    logic       s1_advance;
    logic       in_range;
    cust_addr_t in_addr;
    room_t      ram_rdata;
    room_t      table_rd;
    logic       tbl_we;
    room_t      tbl_wdata;

    assign in_addr    = ADDR_W'(s_tdata[CUST_W-1:0]);
    assign in_range   = (32'(s_tdata[CUST_W-1:0]) < MAX_CUSTOMERS);
    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;
    assign tbl_we     = s1_advance && s1_in_range_reg;

    lfra_ram #(
        .WIDTH (ROOM_W),
        .DEPTH (MAX_CUSTOMERS)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (s1_addr_reg),
        .wdata (tbl_wdata),
        .re    (s_accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        logic             found;
        logic [IDX_W-1:0] found_idx;
        logic [IDX_W-1:0] dep_idx;

        found         = 1'b0;
        found_idx     = '0;
        free_map_next = free_map_reg;
        opened_next   = opened_reg;
        out_room_next = '0;
        out_full_next = 1'b0;
        tbl_wdata     = '0;

        table_rd = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg
                                                                     : ram_rdata;

        // Priority encoder: scanning from the top leaves the lowest free room.
        for (int k = MAX_ROOMS - 1; k >= 0; k--)
        begin
            if (free_map_reg[k])
            begin
                found     = 1'b1;
                found_idx = IDX_W'(k);
            end
        end

        dep_idx = IDX_W'(table_rd - room_t'(1));

        if (s1_in_range_reg)
        begin
            unique case (s1_cmd_reg)
                CMD_ARRIVAL:
                begin
                    priority if (found)
                    begin
                        free_map_next[found_idx] = 1'b0;
                        out_room_next = room_t'(found_idx) + room_t'(1);
                    end
                    else if (opened_reg < room_t'(MAX_ROOMS))
                    begin
                        opened_next   = opened_reg + room_t'(1);
                        out_room_next = opened_reg + room_t'(1);
                    end
                    else
                    begin
                        out_full_next = 1'b1;
                    end
                    tbl_wdata = out_room_next;
                end
                CMD_DEPARTURE:
                begin
                    if ((table_rd != '0) && (table_rd <= opened_reg) &&
                        !free_map_reg[dep_idx])
                    begin
                        free_map_next[dep_idx] = 1'b1;
                        out_room_next = table_rd;
                    end
                end
                default:
                begin
                    out_room_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            free_map_reg  <= '0;
            opened_reg    <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
                free_map_reg  <= free_map_next;
                opened_reg    <= opened_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (tbl_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_cmd_reg      <= cmd_t'(s_tuser);
            s1_addr_reg     <= in_addr;
            s1_in_range_reg <= in_range;
        end
        if (tbl_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= tbl_wdata;
        end
        if (s1_advance)
        begin
            out_room_reg <= out_room_next;
            out_full_reg <= out_full_next;
        end
    end

    // The open room count in the result is the one after that request, so it
    // is captured from the next state value together with the result.
    logic [ROOM_OUT_W-1:0] rooms_opened_shown_reg;

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            rooms_opened_shown_reg <= ROOM_OUT_W'(opened_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_full_reg, rooms_opened_shown_reg,
                                   ROOM_OUT_W'(out_room_reg)});

endmodule
